/* rtl/bpp_pkg.sv */
`timescale 1ns / 1ps
package bpp_pkg;
  localparam int NUM_FIELDS = 4;
  localparam int FUSED_BITS = 32;
  localparam logic [2:0] REG_ACTIVE = 3'd0;
  localparam logic [2:0] REG_W0     = 3'd1;
  localparam logic [2:0] REG_W3     = 3'd4;
endpackage

/* rtl/bpp_div_cell.sv */
`timescale 1ns / 1ps
// one restoring-division step per cell; the quotient bit leaves through the
// shifted numerator register and the partial remainder travels to the next cell
module bpp_div_cell #(
  parameter int NB = 48,
  parameter int DB = 35
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [DB-1:0] din,
  input  logic [DB:0]   rin,
  input  logic [NB-1:0] nin,
  output logic          vout,
  output logic [DB-1:0] dout,
  output logic [DB:0]   rout,
  output logic [NB-1:0] nout
);
  logic [DB+1:0] trial;
  logic [DB+1:0] diff;
  logic          ge;

  // shift in the next numerator bit and try to subtract
  always_comb begin
    trial = {rin, nin[NB-1]};
    diff  = trial - {2'b00, din};
    ge    = !diff[DB+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= din;
      rout <= ge ? diff[DB:0] : trial[DB:0];
      nout <= {nin[NB-2:0], ge};
    end
  end
endmodule

/* rtl/bpp_lane.sv */
`timescale 1ns / 1ps
// one band: a chain of NB division cells, then saturation
module bpp_lane #(
  parameter int NB = 48,
  parameter int DB = 35
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  logic [NB-1:0] num,
  input  logic [DB-1:0] den,
  output logic          vout,
  output logic [31:0]   quo,
  output logic          sat
);
  logic          v [NB+1];
  logic [DB-1:0] d [NB+1];
  logic [DB:0]   r [NB+1];
  logic [NB-1:0] n [NB+1];

  assign v[0] = vin;
  assign d[0] = den;
  assign r[0] = '0;
  assign n[0] = num;

  for (genvar i = 0; i < NB; i++) begin : g_cell
    bpp_div_cell #(.NB(NB), .DB(DB)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vin(v[i]), .din(d[i]), .rin(r[i]), .nin(n[i]),
      .vout(v[i+1]), .dout(d[i+1]), .rout(r[i+1]), .nout(n[i+1])
    );
  end

  // clip the quotient to 32 bits
  assign vout = v[NB];
  if (NB > 32) begin : g_sat
    assign sat = |n[NB][NB-1:32];
    assign quo = sat ? 32'hFFFF_FFFF : n[NB][31:0];
  end else begin : g_nosat
    assign sat = 1'b0;
    assign quo = 32'(n[NB]);
  end
endmodule

/* rtl/brovey_pansharpen_pixel.sv */
`timescale 1ns / 1ps
// Weighted Brovey pansharpening, one pixel per beat, one beat in per clock.
// A result travels from its input beat through a product stage, a weighted-sum
// stage, one restoring-division cell per numerator bit in each band lane, and
// the output register. The whole chain stalls together when the output is
// held, so throughput is one pixel per clock whenever the downstream side
// takes it.
module brovey_pansharpen_pixel #(
  parameter int MAX_BANDS = 4,
  parameter int SAMPLE_BITS = 16,
  parameter int WEIGHT_FRAC_BITS = 12
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pan_sample, band0_sample, band1_sample, band2_sample, band3_sample
  input  logic [79:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // fused0, fused1, fused2, fused3
  output logic [127:0] m_tdata,
  // saturated
  output logic         m_tuser
);
  localparam int NF = bpp_pkg::NUM_FIELDS;
  localparam int NL = (MAX_BANDS < NF) ? MAX_BANDS : NF;
  localparam int PB = 2 * SAMPLE_BITS;
  localparam int NB = PB + WEIGHT_FRAC_BITS;
  localparam int WB = 16;
  localparam int DB = SAMPLE_BITS + WB + 3;
  localparam logic [2:0] NL3 = 3'(NL);

  logic [2:0]  active_bands;
  logic [WB-1:0] weight [NF];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_bands <= 3'd4;
      for (int i = 0; i < NF; i++) weight[i] <= 16'd4096;
    end else if (cfg_we) begin
      if (cfg_index == bpp_pkg::REG_ACTIVE) active_bands <= cfg_data[2:0];
      else if (cfg_index >= bpp_pkg::REG_W0 && cfg_index <= bpp_pkg::REG_W3)
        weight[cfg_index[1:0] - 2'd1] <= cfg_data;
    end
  end

  logic [2:0] nb;
  always_comb begin
    nb = active_bands;
    if (nb == 3'd0) nb = 3'd1;
    if (nb > NL3) nb = NL3;
  end

  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: products
  logic v1;
  logic [PB-1:0] bp [NL];
  logic [DB-1:0] bw [NL];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int b = 0; b < NL; b++) begin
        if (3'(b) < nb) begin
          bp[b] <= PB'(s_tdata[16*(b+1) +: SAMPLE_BITS]) * PB'(s_tdata[SAMPLE_BITS-1:0]);
          bw[b] <= DB'(s_tdata[16*(b+1) +: SAMPLE_BITS]) * DB'(weight[b]);
        end else begin
          bp[b] <= '0;
          bw[b] <= '0;
        end
      end
    end
  end

  // stage 2: denominator sum and numerator scaling
  logic v2;
  logic [DB-1:0] den;
  logic [NB-1:0] num [NL];
  logic [DB-1:0] dsum;
  always_comb begin
    dsum = '0;
    for (int b = 0; b < NL; b++) dsum = dsum + bw[b];
  end
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      den <= (dsum == '0) ? DB'(1) << WEIGHT_FRAC_BITS : dsum;
      for (int b = 0; b < NL; b++) num[b] <= {bp[b], {WEIGHT_FRAC_BITS{1'b0}}};
    end
  end

  // division lanes
  logic        lv [NL];
  logic [31:0] lq [NL];
  logic        ls [NL];
  for (genvar b = 0; b < NL; b++) begin : g_lane
    bpp_lane #(.NB(NB), .DB(DB)) u_lane (
      .clk(clk), .rst(rst), .en(en), .vin(v2), .num(num[b]), .den(den),
      .vout(lv[b]), .quo(lq[b]), .sat(ls[b])
    );
  end

  // output register
  logic sat_any;
  always_comb begin
    sat_any = 1'b0;
    for (int b = 0; b < NL; b++) sat_any = sat_any | ls[b];
  end
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= lv[0];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= '0;
      for (int b = 0; b < NL; b++) m_tdata[32*b +: 32] <= lq[b];
      m_tuser <= sat_any;
    end
  end

  // a held output beat keeps its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");
  // saturation implies some lane reads all ones
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[31:0] == 32'hFFFF_FFFF ||
      m_tdata[63:32] == 32'hFFFF_FFFF || m_tdata[95:64] == 32'hFFFF_FFFF ||
      m_tdata[127:96] == 32'hFFFF_FFFF))
    else $error("saturation flag without clipped value");
  // lanes stay in lock step
  a_lock: assert property (@(posedge clk) disable iff (rst)
    lv[0] == lv[NL-1])
    else $error("lane valids diverged");
endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  localparam int LATENCY = 46;
  localparam int LIMIT = 1500000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [79:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [127:0] m_tdata;
  logic m_tuser;

  typedef struct packed {
    logic [31:0] fused3, fused2, fused1, fused0;
    logic sat;
  } pixel_t;

  // shadow of the block's registers
  logic [2:0] act_bands = 3'd4;
  logic [15:0] weight [bpp_pkg::NUM_FIELDS] = '{16'd4096, 16'd4096, 16'd4096, 16'd4096};

  pixel_t fused_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_off = 0;

  brovey_pansharpen_pixel u_top (.*);

  always #5 clk = ~clk;

  // weighted brovey fusion of one pixel
  function automatic pixel_t fuse_pixel(logic [79:0] px);
    pixel_t r;
    int n;
    logic [63:0] den, num, q;
    logic [15:0] pan, bs;
    n = act_bands;
    if (n < 1) n = 1;
    if (n > bpp_pkg::NUM_FIELDS) n = bpp_pkg::NUM_FIELDS;
    pan = px[15:0];
    den = 0;
    for (int b = 0; b < n; b++) den += 64'(px[16*(b+1) +: 16]) * weight[b];
    if (den == 0) den = 64'd4096;
    r = '0;
    for (int b = 0; b < bpp_pkg::NUM_FIELDS; b++) begin
      q = 0;
      if (b < n) begin
        bs = px[16*(b+1) +: 16];
        num = (64'(bs) * pan) << 12;
        q = num / den;
        if (q > 64'hFFFF_FFFF) begin
          q = 64'hFFFF_FFFF;
          r.sat = 1;
        end
      end
      case (b)
        0: r.fused0 = q[31:0];
        1: r.fused1 = q[31:0];
        2: r.fused2 = q[31:0];
        default: r.fused3 = q[31:0];
      endcase
    end
    return r;
  endfunction

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stall control
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_off <= HOLD_CYCLES - 1;
      m_tready <= 0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // result check
  always @(posedge clk) begin
    pixel_t got, exp_px;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[127:96], m_tdata[95:64], m_tdata[63:32], m_tdata[31:0], m_tuser};
      if (fused_q.size() == 0) begin
        $display("%0t unexpected beat: got %h", $realtime, got);
        errors++;
      end else begin
        exp_px = fused_q.pop_front();
        if (got.fused0 !== exp_px.fused0 || got.fused1 !== exp_px.fused1 ||
            got.fused2 !== exp_px.fused2 || got.fused3 !== exp_px.fused3 ||
            got.sat !== exp_px.sat) begin
          $display("%0t mismatch: expected %h actual %h", $realtime, exp_px, got);
          errors++;
        end
      end
    end
  end

  task automatic send_pixel(logic [79:0] px);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fused_q.push_back(fuse_pixel(px));
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (fused_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == bpp_pkg::REG_ACTIVE) act_bands = val[2:0];
    else if (idx <= bpp_pkg::REG_W3) weight[2'(idx - bpp_pkg::REG_W0)] = val;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [79:0] rand_pixel();
    return {rand_sample(), rand_sample(), rand_sample(), rand_sample(), rand_sample()};
  endfunction

  // extremes, zero denominator, saturation, band counts
  task automatic test_directed();
    send_pixel('0);
    send_pixel('1);
    send_pixel({16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF});
    send_pixel({16'h0, 16'h0, 16'h0, 16'h1, 16'hFFFF});
    send_pixel({16'h1, 16'h1, 16'h1, 16'hFFFF, 16'hFFFF});
    drain();
    write_reg(bpp_pkg::REG_W0, 16'd1);
    write_reg(bpp_pkg::REG_W0 + 3'd1, 16'd0);
    write_reg(bpp_pkg::REG_W0 + 3'd2, 16'd0);
    write_reg(bpp_pkg::REG_W0 + 3'd3, 16'd0);
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h1, 16'hFFFF});
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'hFFFF});
    drain();
    for (int n = 0; n < 8; n++) begin
      write_reg(bpp_pkg::REG_ACTIVE, 16'(n));
      send_pixel({16'h1234, 16'h00FF, 16'hFFFF, 16'h8000, 16'hABCD});
      send_pixel('1);
      drain();
    end
    write_reg(3'd5, 16'h1111);
    write_reg(3'd7, 16'h2222);
    write_reg(bpp_pkg::REG_W0, 16'hFFFF);
    write_reg(bpp_pkg::REG_W0 + 3'd1, 16'hFFFF);
    write_reg(bpp_pkg::REG_W0 + 3'd2, 16'hFFFF);
    write_reg(bpp_pkg::REG_W0 + 3'd3, 16'hFFFF);
    write_reg(bpp_pkg::REG_ACTIVE, 16'd4);
    send_pixel('1);
    send_pixel({16'h1, 16'h1, 16'h1, 16'h1, 16'hFFFF});
    drain();
  endtask

  task automatic random_config();
    write_reg(bpp_pkg::REG_ACTIVE, 16'($urandom_range(7)));
    for (int i = 0; i < bpp_pkg::NUM_FIELDS; i++)
      write_reg(bpp_pkg::REG_W0 + 3'(i),
                ($urandom_range(3) == 0) ? 16'($urandom_range(4)) :
                ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom));
  endtask

  // random pixels under the four idling mixes
  task automatic test_random();
    int sidle [4] = '{0, 69, 0, 37};
    int rstall [4] = '{0, 0, 69, 37};
    for (int p = 0; p < 4; p++) begin
      send_idle = sidle[p];
      recv_stall = rstall[p];
      for (int s = 0; s < 5; s++) begin
        random_config();
        repeat (85) send_pixel(rand_pixel());
        drain();
      end
    end
    send_idle = 0;
    recv_stall = 0;
  endtask

  // long receiver hold-off while the sender keeps going
  task automatic test_backpressure();
    random_config();
    hold_req = hold_req + 1;
    repeat (120) send_pixel(rand_pixel());
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
